// File: hw/rtl/dqf_pkg.sv
// shared types, constants and helper functions of the distance quadruple filter
`timescale 1ns / 1ps
package dqf_pkg;

  // field widths
  localparam int VAL_W  = 32;
  localparam int SUM_W  = 33;
  localparam int ST_W   = 3;
  localparam int SQ_W   = 64;
  localparam int RAD_W  = 66;   // radicand padded to an even width
  localparam int ROOT_W = 33;
  localparam int REM_W  = 35;
  localparam int NCELLS = RAD_W / 2;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SUM_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARITY_EN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOD3_EN     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THREE_COND  = 2'd3;

  // reset values
  localparam logic [VAL_W-1:0] SUM_LIMIT_RST = 32'd1000000;

  // status codes
  localparam logic [ST_W-1:0] ST_OVER   = 3'd0;
  localparam logic [ST_W-1:0] ST_NOTPOS = 3'd1;
  localparam logic [ST_W-1:0] ST_FILT   = 3'd2;
  localparam logic [ST_W-1:0] ST_NO     = 3'd3;
  localparam logic [ST_W-1:0] ST_YES    = 3'd4;

  // side data that travels with an item
  typedef struct packed {
    logic [ST_W-1:0]  status;   // early status, or ST_NO for a tested item
    logic [SUM_W-1:0] q;
    logic [VAL_W-1:0] d;
    logic             three;
  } meta_t;

  // one square root lane
  typedef struct packed {
    logic [RAD_W-1:0]  n;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } lane_t;

  // true when v is a multiple of three (base-4 digit folding)
  function automatic logic is_mult3(input logic [VAL_W-1:0] v);
    logic [5:0] s;
    logic [3:0] s2;
    logic [2:0] s3;
    s = '0;
    for (int i = 0; i < VAL_W / 2; i++) begin
      s = s + 6'(v[2*i +: 2]);
    end
    s2 = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]);
    s3 = 3'(s2[1:0]) + 3'(s2[3:2]);
    return (s3 == 3'd0) || (s3 == 3'd3);
  endfunction

  // one digit of a restoring square root
  function automatic lane_t sqrt_step(input lane_t l);
    lane_t r;
    logic [REM_W+1:0] rs;
    logic [REM_W+1:0] trial;
    rs    = {l.rem, l.n[RAD_W-1 -: 2]};
    trial = (REM_W + 2)'({l.root, 2'b01});
    r.n   = {l.n[RAD_W-3:0], 2'b00};
    if (rs >= trial) begin
      r.rem  = REM_W'(rs - trial);
      r.root = {l.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = REM_W'(rs);
      r.root = {l.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/dqf_front.sv
// front stages: classify, square the operands, form the two radicands
`timescale 1ns / 1ps
module dqf_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [dqf_pkg::VAL_W-1:0]   a,
  input  logic [dqf_pkg::VAL_W-1:0]   b,
  input  logic [dqf_pkg::VAL_W-1:0]   c,
  input  logic [dqf_pkg::VAL_W-1:0]   sum_limit,
  input  logic                        parity_en,
  input  logic                        mod3_en,
  input  logic                        three_cond,
  output logic                        out_valid,
  output dqf_pkg::meta_t              out_meta,
  output dqf_pkg::lane_t              out_lane_a,
  output dqf_pkg::lane_t              out_lane_b
);

  logic                       v1_r, v2_r, v3_r;
  dqf_pkg::meta_t             m1_r, m1_nxt, m2_r, m3_r;
  logic [dqf_pkg::VAL_W-1:0]  a1_r, b1_r, d1_r;
  logic [dqf_pkg::SQ_W-1:0]   aa2_r, bb2_r, dd2_r;
  logic [dqf_pkg::SQ_W:0]     na3_r, nb3_r;

  logic [dqf_pkg::SUM_W-1:0]  q;
  logic [dqf_pkg::VAL_W-1:0]  d;
  logic                       over, notpos, par_ok, m3_ok, filt;

  // classification
  always_comb begin
    q      = {1'b0, a} + {1'b0, b};
    d      = q[dqf_pkg::VAL_W-1:0] - c;
    over   = q > {1'b0, sum_limit};
    notpos = q <= {1'b0, c};
    par_ok = (a[0] && b[0] && (c[1:0] == 2'b00) && (d[1:0] == 2'b00)) ||
             (c[0] && d[0] && (a[1:0] == 2'b00) && (b[1:0] == 2'b00));
    m3_ok  = (dqf_pkg::is_mult3(a) && dqf_pkg::is_mult3(b)) ||
             (dqf_pkg::is_mult3(c) && dqf_pkg::is_mult3(d));
    filt   = (parity_en && !par_ok) || (mod3_en && !m3_ok);
    m1_nxt.q     = q;
    m1_nxt.three = three_cond;
    m1_nxt.d     = d;
    if (over) begin
      m1_nxt.status = dqf_pkg::ST_OVER;
      m1_nxt.d      = '0;
    end else if (notpos) begin
      m1_nxt.status = dqf_pkg::ST_NOTPOS;
      m1_nxt.d      = '0;
    end else if (filt) begin
      m1_nxt.status = dqf_pkg::ST_FILT;
    end else begin
      m1_nxt.status = dqf_pkg::ST_NO;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      m1_r  <= m1_nxt;
      a1_r  <= a;
      b1_r  <= b;
      d1_r  <= d;
      m2_r  <= m1_r;
      aa2_r <= a1_r * a1_r;
      bb2_r <= b1_r * b1_r;
      dd2_r <= d1_r * d1_r;
      m3_r  <= m2_r;
      na3_r <= {1'b0, aa2_r} + {1'b0, dd2_r};
      nb3_r <= {1'b0, bb2_r} + {1'b0, dd2_r};
    end
  end

  assign out_valid       = v3_r;
  assign out_meta        = m3_r;
  assign out_lane_a.n    = {1'b0, na3_r};
  assign out_lane_a.rem  = '0;
  assign out_lane_a.root = '0;
  assign out_lane_b.n    = {1'b0, nb3_r};
  assign out_lane_b.rem  = '0;
  assign out_lane_b.root = '0;

endmodule

// File: hw/rtl/dqf_cell.sv
// one square root cell: resolves one root digit of both lanes
`timescale 1ns / 1ps
module dqf_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  dqf_pkg::meta_t in_meta,
  input  dqf_pkg::lane_t in_lane_a,
  input  dqf_pkg::lane_t in_lane_b,
  output logic           out_valid,
  output dqf_pkg::meta_t out_meta,
  output dqf_pkg::lane_t out_lane_a,
  output dqf_pkg::lane_t out_lane_b
);

  logic           valid_r;
  dqf_pkg::meta_t meta_r;
  dqf_pkg::lane_t lane_a_r, lane_b_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  // digit step
  always_ff @(posedge clk) begin
    if (en) begin
      meta_r   <= in_meta;
      lane_a_r <= dqf_pkg::sqrt_step(in_lane_a);
      lane_b_r <= dqf_pkg::sqrt_step(in_lane_b);
    end
  end

  assign out_valid  = valid_r;
  assign out_meta   = meta_r;
  assign out_lane_a = lane_a_r;
  assign out_lane_b = lane_b_r;

endmodule

// File: hw/rtl/distance_quadruple_filter_unit.sv
// top level of the distance quadruple filter
`timescale 1ns / 1ps
// Usage:
//   in_*  : one candidate triple per item, tdata = {c, b, a}, a in the low bits.
//   out_* : one result per input item, in the same order.
//   cfg_* : register writes, taken whenever cfg_wen is high; write only
//           while the block is idle.
// The pipeline has one classify stage, one squaring stage, one add stage
// and a chain of 33 square root cells, each resolving one root digit
// of both radicands.
// Throughput is one item per cycle; every stage is a register stage.
// The whole pipeline advances together: when the receiver stalls with a
// result waiting, all stages hold and in_tready drops; bubbles fill in
// while out_tvalid is low.
// Synchronous reset clears all valid bits and loads the register
// defaults (sum_limit 1000000, parity filter on, mod-3 filter off,
// three-condition mode off).
module distance_quadruple_filter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // first_partner, second_partner, common_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // status, pair_sum, difference, zero fill
  input  logic        cfg_wen,
  input  logic [dqf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int N = dqf_pkg::NCELLS;

  logic [dqf_pkg::VAL_W-1:0] sum_limit_r;
  logic                      parity_en_r, mod3_en_r, three_r;
  logic                      en;

  logic           cv [N+1];
  dqf_pkg::meta_t cm [N+1];
  dqf_pkg::lane_t ca [N+1];
  dqf_pkg::lane_t cb [N+1];

  dqf_pkg::meta_t  fm;
  logic            ok_a, ok_b;
  logic [dqf_pkg::ST_W-1:0] status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_limit_r <= dqf_pkg::SUM_LIMIT_RST;
      parity_en_r <= 1'b1;
      mod3_en_r   <= 1'b0;
      three_r     <= 1'b0;
    end else if (cfg_wen) begin
      case (cfg_index)
        dqf_pkg::REG_SUM_LIMIT:  sum_limit_r <= cfg_wdata;
        dqf_pkg::REG_PARITY_EN:  parity_en_r <= cfg_wdata[0];
        dqf_pkg::REG_MOD3_EN:    mod3_en_r   <= cfg_wdata[0];
        dqf_pkg::REG_THREE_COND: three_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // pipeline advance
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  dqf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_tvalid),
    .a          (in_tdata[31:0]),
    .b          (in_tdata[63:32]),
    .c          (in_tdata[95:64]),
    .sum_limit  (sum_limit_r),
    .parity_en  (parity_en_r),
    .mod3_en    (mod3_en_r),
    .three_cond (three_r),
    .out_valid  (cv[0]),
    .out_meta   (cm[0]),
    .out_lane_a (ca[0]),
    .out_lane_b (cb[0])
  );

  // square root chain
  for (genvar i = 0; i < N; i++) begin : g_cell
    dqf_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .in_valid   (cv[i]),
      .in_meta    (cm[i]),
      .in_lane_a  (ca[i]),
      .in_lane_b  (cb[i]),
      .out_valid  (cv[i+1]),
      .out_meta   (cm[i+1]),
      .out_lane_a (ca[i+1]),
      .out_lane_b (cb[i+1])
    );
  end

  // final status
  always_comb begin
    fm   = cm[N];
    ok_a = (ca[N].rem == '0);
    ok_b = (cb[N].rem == '0) || fm.three;
    if (fm.status == dqf_pkg::ST_NO && ok_a && ok_b) begin
      status = dqf_pkg::ST_YES;
    end else begin
      status = fm.status;
    end
  end

  assign out_tvalid = cv[N];
  assign out_tdata  = {4'b0, fm.d, fm.q, status};

`ifndef SYNTHESIS
  a_early_zero_d : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == dqf_pkg::ST_OVER ||
                   out_tdata[2:0] == dqf_pkg::ST_NOTPOS)
    |-> out_tdata[67:36] == 32'd0)
    else $error("early exit carries a nonzero difference");
  a_status_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= dqf_pkg::ST_YES)
    else $error("status code out of range");
  a_d_below_q : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> {1'b0, out_tdata[67:36]} <= out_tdata[35:3])
    else $error("difference exceeds pair sum");
  a_reset_idle : assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_tvalid)
    else $error("result shown right after reset");
`endif

endmodule
